FILE: rtl/pidt_pkg.sv
// Package for the process ID table: sizes, command and status codes, and
// the field layout of the input and result streams. No dependencies.
`default_nettype none

package pidt_pkg;

  // Identifiers run from FIRST_ID to FIRST_ID + NUM_IDS - 1.
  localparam int FIRST_ID = 2;
  localparam int NUM_IDS  = 64;

  localparam int ID_W   = 7;
  localparam int EXIT_W = 32;
  localparam int SLOT_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  // Width that holds any identifier and the end of the identifier range.
  localparam int CMP_W  = ((ID_W > SLOT_W) ? ID_W : SLOT_W) + 6;

  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam int IN_BITS   = CMD_W + 3 * ID_W + EXIT_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STAT_W + 2 * ID_W + 3 + EXIT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_REG     = 3'd2,
    CMD_SETEXIT = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   asker_id;
    logic [EXIT_W-1:0] exit_value;
    logic [ID_W-1:0]   parent_id;
    logic [ID_W-1:0]   target_id;
    logic [CMD_W-1:0]  cmd;
  } req_t;

  typedef struct packed {
    logic              is_child;
    logic [ID_W-1:0]   parent_out;
    logic [EXIT_W-1:0] exit_out;
    logic              is_running;
    logic              present;
    logic [ID_W-1:0]   new_id;
    logic [STAT_W-1:0] status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/process_id_table.sv
// Process ID table top level: lowest-free ID allocator with per-ID records.
// Depends on pidt_pkg for sizes, codes and stream field layout.
//
//  Channel   | Direction | Payload (lowest bit first)
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | cmd, target_id, parent_id, exit_value, asker_id
//  m_axis    | out       | status, new_id, present, is_running, exit_out,
//            |           | parent_out, is_child, zero fill
//
// One request enters per cycle while the output is not stalled. The record
// memories are read as a request is taken, the command executes in the
// execute stage against the in-use bitmap, and its result lands in the output
// register. The lowest free ID comes from a priority encoder over the bitmap.
// Reset clears the bitmap and the valid flags, not the record memories; those
// are always written by allocate before their contents are used. A stalled
// output holds the request in flight and stops intake.
`default_nettype none

module process_id_table (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // cmd[2:0], target_id[9:3], parent_id[16:10], exit_value[48:17], asker_id[55:49]
  input  wire  [pidt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  // status[1:0], new_id[8:2], present[9], is_running[10], exit_out[42:11],
  // parent_out[49:43], is_child[50], zeros above
  output logic [pidt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import pidt_pkg::*;

  localparam logic [CMP_W-1:0] ID_LO = CMP_W'(FIRST_ID);
  localparam logic [CMP_W-1:0] ID_HI = CMP_W'(FIRST_ID + NUM_IDS);

  // Input side.
  req_t              in_req;
  logic              in_fire;
  logic [CMP_W-1:0]  tgt_ext;
  logic [SLOT_W-1:0] in_slot;
  logic              in_range;

  // Execute stage.
  logic              s1_valid_q;
  req_t              s1_req_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              s1_range_q;
  logic              s1_fire;

  // Record memories and their registered read data.
  logic [ID_W-1:0]   par_mem  [NUM_IDS];
  logic [EXIT_W-1:0] exit_mem [NUM_IDS];
  logic              run_mem  [NUM_IDS];
  logic [ID_W-1:0]   par_rd_q;
  logic [EXIT_W-1:0] exit_rd_q;
  logic              run_rd_q;

  // Last write to each memory, forwarded over the read taken in the same cycle.
  logic              fwd_par_vld_q, fwd_exit_vld_q, fwd_run_vld_q;
  logic [SLOT_W-1:0] fwd_par_slot_q, fwd_exit_slot_q, fwd_run_slot_q;
  logic [ID_W-1:0]   fwd_par_q;
  logic [EXIT_W-1:0] fwd_exit_q;
  logic              fwd_run_q;

  logic [ID_W-1:0]   cur_par;
  logic [EXIT_W-1:0] cur_exit;
  logic              cur_run;

  logic [NUM_IDS-1:0] in_use_q, in_use_d;
  logic [SLOT_W-1:0]  free_slot;
  logic               tbl_full;
  logic               hit;

  logic              wr_par, wr_exit, wr_run;
  logic [SLOT_W-1:0] wr_slot;
  logic [ID_W-1:0]   wr_par_val;
  logic [EXIT_W-1:0] wr_exit_val;
  logic              wr_run_val;

  rsp_t rsp;
  logic out_valid_q;
  rsp_t out_rsp_q;

  assign in_req   = req_t'(s_axis_tdata_i[IN_BITS-1:0]);
  assign tgt_ext  = CMP_W'(in_req.target_id);
  assign in_range = (tgt_ext >= ID_LO) && (tgt_ext < ID_HI);
  assign in_slot  = SLOT_W'(tgt_ext - ID_LO);

  assign s1_fire         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q   <= in_req;
      s1_slot_q  <= in_slot;
      s1_range_q <= in_range;
      par_rd_q   <= par_mem[in_slot];
      exit_rd_q  <= exit_mem[in_slot];
      run_rd_q   <= run_mem[in_slot];
    end
  end

  assign cur_par  = (fwd_par_vld_q && fwd_par_slot_q == s1_slot_q) ? fwd_par_q : par_rd_q;
  assign cur_exit = (fwd_exit_vld_q && fwd_exit_slot_q == s1_slot_q) ? fwd_exit_q : exit_rd_q;
  assign cur_run  = (fwd_run_vld_q && fwd_run_slot_q == s1_slot_q) ? fwd_run_q : run_rd_q;

  // Lowest free entry: scan from the top so the lowest clear bit wins.
  always_comb begin
    free_slot = '0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign tbl_full = &in_use_q;
  assign hit      = s1_range_q && in_use_q[s1_slot_q];

  always_comb begin
    rsp         = '0;
    rsp.status  = ST_BAD;
    in_use_d    = in_use_q;
    wr_par      = 1'b0;
    wr_exit     = 1'b0;
    wr_run      = 1'b0;
    wr_slot     = s1_slot_q;
    wr_par_val  = '0;
    wr_exit_val = '0;
    wr_run_val  = 1'b0;
    case (s1_req_q.cmd)
      CMD_ALLOC: begin
        if (tbl_full) begin
          rsp.status = ST_FULL;
        end else begin
          rsp.status          = ST_OK;
          rsp.new_id          = ID_W'(CMP_W'(free_slot) + ID_LO);
          in_use_d[free_slot] = 1'b1;
          wr_slot             = free_slot;
          wr_par              = 1'b1;
          wr_exit             = 1'b1;
          wr_run              = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (hit) begin
          rsp.status          = ST_OK;
          in_use_d[s1_slot_q] = 1'b0;
        end
      end
      CMD_REG: begin
        if (hit) begin
          rsp.status = ST_OK;
          wr_par     = 1'b1;
          wr_par_val = s1_req_q.parent_id;
          wr_exit    = 1'b1;
          wr_run     = 1'b1;
          wr_run_val = 1'b1;
        end
      end
      CMD_SETEXIT: begin
        if (hit) begin
          rsp.status  = ST_OK;
          wr_exit     = 1'b1;
          wr_exit_val = s1_req_q.exit_value;
        end
      end
      CMD_STOP: begin
        if (hit) begin
          rsp.status = ST_OK;
          wr_run     = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (hit) begin
          rsp.status     = ST_OK;
          rsp.present    = 1'b1;
          rsp.is_running = cur_run;
          rsp.exit_out   = cur_exit;
          rsp.parent_out = cur_par;
          rsp.is_child   = (s1_req_q.asker_id == cur_par);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q       <= '0;
      fwd_par_vld_q  <= 1'b0;
      fwd_exit_vld_q <= 1'b0;
      fwd_run_vld_q  <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (s1_fire) begin
        in_use_q <= in_use_d;
        if (wr_par) begin
          fwd_par_vld_q <= 1'b1;
        end
        if (wr_exit) begin
          fwd_exit_vld_q <= 1'b1;
        end
        if (wr_run) begin
          fwd_run_vld_q <= 1'b1;
        end
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_rsp_q <= rsp;
      if (wr_par) begin
        par_mem[wr_slot] <= wr_par_val;
        fwd_par_slot_q   <= wr_slot;
        fwd_par_q        <= wr_par_val;
      end
      if (wr_exit) begin
        exit_mem[wr_slot] <= wr_exit_val;
        fwd_exit_slot_q   <= wr_slot;
        fwd_exit_q        <= wr_exit_val;
      end
      if (wr_run) begin
        run_mem[wr_slot] <= wr_run_val;
        fwd_run_slot_q   <= wr_slot;
        fwd_run_q        <= wr_run_val;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_rsp_q);

endmodule

`default_nettype wire

FILE: bench/process_id_table_tb.sv
// Self-checking bench for the process ID table: directed requests, a fill to
// full, then random traffic with random stalls on both streams.
// Depends on pidt_pkg and the process_id_table RTL only.

module process_id_table_tb;
  import pidt_pkg::*;

  localparam int LAST_ID      = FIRST_ID + NUM_IDS - 1;
  localparam int NUM_RANDOM   = 1500;
  localparam int PHASE_LEN    = 200;
  localparam int MODE_LEN     = 100;
  localparam int MAX_GAP      = 18;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  localparam logic [ID_W-1:0]   ID_ZERO   = '0;
  localparam logic [ID_W-1:0]   ID_ONE    = ID_W'(1);
  localparam logic [ID_W-1:0]   ID_FIRST  = ID_W'(FIRST_ID);
  localparam logic [ID_W-1:0]   ID_SECOND = ID_W'(FIRST_ID + 1);
  localparam logic [ID_W-1:0]   ID_LAST   = ID_W'(LAST_ID);
  localparam logic [ID_W-1:0]   ID_PAST   = ID_W'(LAST_ID + 1);
  localparam logic [ID_W-1:0]   ID_TOP    = '1;
  localparam logic [EXIT_W-1:0] EXIT_ZERO = '0;
  localparam logic [EXIT_W-1:0] EXIT_ONES = '1;
  localparam logic [EXIT_W-1:0] EXIT_MIN  = 32'h8000_0000;
  localparam logic [EXIT_W-1:0] EXIT_MAX  = 32'h7FFF_FFFF;
  localparam logic              KNOWN     = 1'b1;
  localparam logic              PREDICT   = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   target_id;
    logic [ID_W-1:0]   parent_id;
    logic [EXIT_W-1:0] exit_value;
    logic [ID_W-1:0]   asker_id;
    logic              typed;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   new_id;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;

  // Rows marked KNOWN carry their status and new ID; all other result fields
  // are zero for them. PREDICT rows are checked against the table model.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_QUERY,    ID_FIRST,  ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_RELEASE,  ID_FIRST,  ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_STOP,     ID_LAST,   ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_UNUSED_A, ID_FIRST,  ID_TOP,  EXIT_ONES, ID_TOP,  KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_UNUSED_B, ID_FIRST,  ID_TOP,  EXIT_ONES, ID_TOP,  KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_ALLOC,    ID_TOP,    ID_TOP,  EXIT_ONES, ID_TOP,  KNOWN,   ST_OK,  ID_FIRST},
    '{CMD_ALLOC,    ID_ZERO,   ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_OK,  ID_SECOND},
    '{CMD_QUERY,    ID_FIRST,  ID_ZERO, EXIT_ZERO, ID_ZERO, PREDICT, ST_OK,  ID_ZERO},
    '{CMD_REG,      ID_SECOND, ID_TOP,  EXIT_ONES, ID_ZERO, KNOWN,   ST_OK,  ID_ZERO},
    '{CMD_SETEXIT,  ID_SECOND, ID_ZERO, EXIT_MIN,  ID_ZERO, KNOWN,   ST_OK,  ID_ZERO},
    '{CMD_QUERY,    ID_SECOND, ID_ZERO, EXIT_ZERO, ID_TOP,  PREDICT, ST_OK,  ID_ZERO},
    '{CMD_SETEXIT,  ID_SECOND, ID_ZERO, EXIT_MAX,  ID_ZERO, KNOWN,   ST_OK,  ID_ZERO},
    '{CMD_QUERY,    ID_SECOND, ID_ZERO, EXIT_ZERO, ID_ZERO, PREDICT, ST_OK,  ID_ZERO},
    '{CMD_STOP,     ID_SECOND, ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_OK,  ID_ZERO},
    '{CMD_QUERY,    ID_SECOND, ID_ZERO, EXIT_ZERO, ID_TOP,  PREDICT, ST_OK,  ID_ZERO},
    '{CMD_REG,      ID_FIRST,  ID_ZERO, EXIT_ONES, ID_ZERO, KNOWN,   ST_OK,  ID_ZERO},
    '{CMD_QUERY,    ID_ZERO,   ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_REG,      ID_ONE,    ID_ONE,  EXIT_ZERO, ID_ZERO, KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_SETEXIT,  ID_PAST,   ID_ZERO, EXIT_ONES, ID_ZERO, KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_RELEASE,  ID_TOP,    ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_RELEASE,  ID_FIRST,  ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_OK,  ID_ZERO},
    '{CMD_QUERY,    ID_FIRST,  ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_BAD, ID_ZERO},
    '{CMD_ALLOC,    ID_ZERO,   ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_OK,  ID_FIRST},
    '{CMD_QUERY,    ID_FIRST,  ID_ZERO, EXIT_ZERO, ID_TOP,  PREDICT, ST_OK,  ID_ZERO},
    '{CMD_STOP,     ID_FIRST,  ID_ZERO, EXIT_ZERO, ID_ZERO, KNOWN,   ST_OK,  ID_ZERO}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Shadow copy of the ID table.
  bit                live [NUM_IDS];
  logic [ID_W-1:0]   parent_of [NUM_IDS];
  logic [EXIT_W-1:0] exit_of [NUM_IDS];
  logic              running_of [NUM_IDS];
  int                live_count;

  rsp_t pending_results [$];
  int   fail_count;
  int   n_requests, n_results, n_granted, n_full, n_rejected, n_query_hits;
  bit   filling;
  int   src_mode, sink_mode;

  process_id_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Applies one command to the shadow table and returns the result it gives.
  function automatic rsp_t apply_command(req_t r);
    rsp_t o;
    int   slot;
    bit   hit;
    o = '0;
    o.status = ST_BAD;
    slot = int'(r.target_id) - FIRST_ID;
    hit = (slot >= 0) && (slot < NUM_IDS) && live[slot];
    case (r.cmd)
      CMD_ALLOC: begin
        o.status = ST_FULL;
        for (int i = 0; i < NUM_IDS; i++) begin
          if (!live[i]) begin
            live[i] = 1'b1;
            parent_of[i] = '0;
            exit_of[i] = '0;
            running_of[i] = 1'b0;
            live_count++;
            o.status = ST_OK;
            o.new_id = ID_W'(FIRST_ID + i);
            break;
          end
        end
      end
      CMD_RELEASE: begin
        if (hit) begin
          live[slot] = 1'b0;
          live_count--;
          o.status = ST_OK;
        end
      end
      CMD_REG: begin
        if (hit) begin
          parent_of[slot] = r.parent_id;
          exit_of[slot] = '0;
          running_of[slot] = 1'b1;
          o.status = ST_OK;
        end
      end
      CMD_SETEXIT: begin
        if (hit) begin
          exit_of[slot] = r.exit_value;
          o.status = ST_OK;
        end
      end
      CMD_STOP: begin
        if (hit) begin
          running_of[slot] = 1'b0;
          o.status = ST_OK;
        end
      end
      CMD_QUERY: begin
        if (hit) begin
          o.status = ST_OK;
          o.present = 1'b1;
          o.is_running = running_of[slot];
          o.exit_out = exit_of[slot];
          o.parent_out = parent_of[slot];
          o.is_child = (r.asker_id == parent_of[slot]);
          n_query_hits++;
        end
      end
      default: ;
    endcase
    if (r.cmd == CMD_ALLOC && o.status == ST_OK) n_granted++;
    if (o.status == ST_FULL) n_full++;
    if (o.status == ST_BAD) n_rejected++;
    return o;
  endfunction

  function automatic int unsigned pick_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, MAX_GAP);
      default: return ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_live_id();
    int s;
    if (live_count == 0) return ID_W'($urandom_range(FIRST_ID, LAST_ID));
    do s = $urandom_range(0, NUM_IDS - 1); while (!live[s]);
    return ID_W'(FIRST_ID + s);
  endfunction

  // Mostly commands on live IDs; the mix leans toward allocate while filling
  // and toward release while draining, so the table swings between both ends.
  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    int          slot;
    r.exit_value = $urandom();
    r.parent_id = ($urandom_range(0, 9) < 6) ? pick_live_id() : ID_W'($urandom_range(0, 127));
    roll = $urandom_range(0, 9);
    if (roll < 8) r.target_id = pick_live_id();
    else if (roll == 8) r.target_id = ID_W'($urandom_range(FIRST_ID, LAST_ID));
    else r.target_id = ID_W'($urandom_range(0, 127));
    slot = int'(r.target_id) - FIRST_ID;
    if (slot >= 0 && slot < NUM_IDS && live[slot] && $urandom_range(0, 1) == 1)
      r.asker_id = parent_of[slot];
    else
      r.asker_id = ID_W'($urandom_range(0, 127));
    roll = $urandom_range(0, 99);
    if (roll < 3) r.cmd = roll[0] ? CMD_UNUSED_A : CMD_UNUSED_B;
    else if (roll < (filling ? 48 : 13)) r.cmd = CMD_ALLOC;
    else if (roll < 58) r.cmd = CMD_RELEASE;
    else if (roll < 68) r.cmd = CMD_REG;
    else if (roll < 76) r.cmd = CMD_SETEXIT;
    else if (roll < 84) r.cmd = CMD_STOP;
    else r.cmd = CMD_QUERY;
    return r;
  endfunction

  task automatic drive_request(req_t r, logic typed, rsp_t given);
    int unsigned gap;
    rsp_t        want;
    gap = pick_gap(src_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= r;
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = apply_command(r);
    if (typed) want = given;
    pending_results.push_back(want);
    n_requests++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic void check_field(string name, logic [EXIT_W-1:0] want,
                                      logic [EXIT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(logic [OUT_DATA_W-1:0] raw);
    rsp_t got, want;
    got = rsp_t'(raw[OUT_BITS-1:0]);
    if (pending_results.size() == 0) begin
      $error("result %h arrived with no request outstanding", raw);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    check_field("status", want.status, got.status);
    check_field("new_id", want.new_id, got.new_id);
    check_field("present", want.present, got.present);
    check_field("is_running", want.is_running, got.is_running);
    check_field("exit_out", want.exit_out, got.exit_out);
    check_field("parent_out", want.parent_out, got.parent_out);
    check_field("is_child", want.is_child, got.is_child);
    check_field("zero_fill", '0, raw[OUT_DATA_W-1:OUT_BITS]);
  endfunction

  initial begin : result_sink
    int unsigned gap;
    m_axis_tready_i = 1'b0;
    sink_mode = 1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (n_results % MODE_LEN == 0) sink_mode = $urandom_range(0, 2);
      gap = pick_gap(sink_mode);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      check_result(m_axis_tdata_o);
      n_results++;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("process_id_table test failed");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    rsp_t given;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    src_mode = 1;
    filling = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < SCRIPT_LEN; k++) begin
      r.cmd = SCRIPT[k].cmd;
      r.target_id = SCRIPT[k].target_id;
      r.parent_id = SCRIPT[k].parent_id;
      r.exit_value = SCRIPT[k].exit_value;
      r.asker_id = SCRIPT[k].asker_id;
      given = '0;
      given.status = SCRIPT[k].status;
      given.new_id = SCRIPT[k].new_id;
      drive_request(r, SCRIPT[k].typed, given);
    end

    // Fill every ID, then hit the full table twice and look at the last ID.
    src_mode = 2;
    while (live_count < NUM_IDS + 2) begin
      r = random_request();
      r.cmd = CMD_ALLOC;
      drive_request(r, PREDICT, '0);
      if (live_count == NUM_IDS && n_full >= 2) break;
    end
    r = random_request();
    r.cmd = CMD_QUERY;
    r.target_id = ID_LAST;
    drive_request(r, PREDICT, '0);
    drain_results();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) filling = ~filling;
      if (n % MODE_LEN == 0) src_mode = $urandom_range(0, 2);
      if (n == NUM_RANDOM / 2) drain_results();
      drive_request(random_request(), PREDICT, '0);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results.", n_requests, n_results);
    $display("IDs granted %0d, full-table refusals %0d, bad or free IDs %0d, queries hit %0d.",
             n_granted, n_full, n_rejected, n_query_hits);
    if (fail_count == 0) begin
      $display("process_id_table test passed");
    end else begin
      $display("process_id_table test failed");
    end
    $finish;
  end

endmodule
